// ===== sv/mapc_pkg.sv =====
// Shared types and constants for the motion alarm PIN controller.
// No dependencies; used by mapc_csr, mapc_core and the top level.
package mapc_pkg;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_MOTION      = 3'd1,
      EV_ADMIN       = 3'd2,
      EV_DIGIT       = 3'd3,
      EV_PIN_OK      = 3'd4,
      EV_PIN_WRONG   = 3'd5,
      EV_REARMED     = 3'd6
   } event_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_CODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REARM_DELAY    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOTE_THRESHOLD = 2'd2;

   localparam logic [15:0] PIN_CODE_RESET       = 16'h1245;
   localparam logic [31:0] REARM_DELAY_RESET    = 32'd60000000;
   localparam logic [2:0]  VOTE_THRESHOLD_RESET = 3'd3;

   localparam logic [7:0] KEY_NONE  = 8'h00;
   localparam logic [7:0] KEY_C     = 8'h43;
   localparam logic [7:0] KEY_D     = 8'h44;
   localparam logic [7:0] KEY_HASH  = 8'h23;
   localparam logic [7:0] KEY_STAR  = 8'h2A;
   localparam logic [7:0] KEY_ZERO  = 8'h30;
   localparam logic [7:0] KEY_NINE  = 8'h39;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 16;

   typedef struct packed {
      logic [15:0] pin_code;
      logic [31:0] rearm_delay_us;
      logic [2:0]  vote_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  key;
      logic        pir_level;
      logic [2:0]  pir_high_count;
      logic [62:0] now_us;
   } item_type;

   typedef struct packed {
      logic      alarm_active;
      logic      admin_active;
      logic      disarmed;
      logic [2:0] digits_entered;
      event_type event_res;
   } result_type;

endpackage

// ===== sv/mapc_csr.sv =====
// Configuration registers of the motion alarm PIN controller.
// Depends on mapc_pkg.
module mapc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [mapc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mapc_pkg::CSR_DATA_W-1:0]     csr_data,
   output mapc_pkg::cfg_type                   cfg
);

   mapc_pkg::cfg_type cfg_ff;
   mapc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mapc_pkg::CSR_PIN_CODE:       cfg_in.pin_code       = csr_data[15:0];
            mapc_pkg::CSR_REARM_DELAY:    cfg_in.rearm_delay_us = csr_data;
            mapc_pkg::CSR_VOTE_THRESHOLD: cfg_in.vote_threshold = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_code       <= mapc_pkg::PIN_CODE_RESET;
         cfg_ff.rearm_delay_us <= mapc_pkg::REARM_DELAY_RESET;
         cfg_ff.vote_threshold <= mapc_pkg::VOTE_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/mapc_core.sv =====
// Alarm state and next-state logic: one tick per step, result is combinational.
// Depends on mapc_pkg.
module mapc_core #(
   parameter int PIN_DIGITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mapc_pkg::item_type   item,
   input  mapc_pkg::cfg_type    cfg,
   output mapc_pkg::result_type result
);

   localparam int CW    = $clog2(PIN_DIGITS + 1);
   localparam int PIN_W = 4 * PIN_DIGITS;

   logic [7:0]    prev_key_ff, prev_key_in;
   logic          sensor_ready_ff, sensor_ready_in;
   logic          alarm_ff, alarm_in;
   logic          admin_ff, admin_in;
   logic [CW-1:0] count_ff, count_in;
   logic          disarm_ff, disarm_in;
   logic [62:0]   stamp_ff, stamp_in;
   logic [3:0]    digit_ff [PIN_DIGITS];

   logic [7:0]       key_eff;
   logic             armed;
   logic             is_admin_key;
   logic             is_digit;
   logic [3:0]       digit_val;
   logic [7:0]       key_off;
   logic             digit_wr;
   logic [CW-1:0]    count_inc;
   logic [PIN_W-1:0] pin_ext;
   logic [3:0]       entry_val [PIN_DIGITS];
   logic             match;
   logic [62:0]      elapsed;
   logic             rearm_due;
   mapc_pkg::event_type ev;

   assign key_eff      = (item.key == prev_key_ff) ? mapc_pkg::KEY_NONE : item.key;
   assign armed        = !alarm_ff && !admin_ff && !disarm_ff;
   assign is_admin_key = (key_eff == mapc_pkg::KEY_C) || (key_eff == mapc_pkg::KEY_D) ||
                         (key_eff == mapc_pkg::KEY_HASH) || (key_eff == mapc_pkg::KEY_STAR);
   assign is_digit     = (key_eff >= mapc_pkg::KEY_ZERO) && (key_eff <= mapc_pkg::KEY_NINE);
   assign key_off      = key_eff - mapc_pkg::KEY_ZERO;
   assign digit_val    = key_off[3:0];
   assign digit_wr     = admin_ff && is_digit && (count_ff < CW'(PIN_DIGITS));
   assign count_inc    = count_ff + CW'(1);
   assign pin_ext      = PIN_W'(cfg.pin_code);
   assign elapsed      = item.now_us - stamp_ff;
   assign rearm_due    = elapsed > {31'd0, cfg.rearm_delay_us};

   always_comb begin
      match = 1'b1;
      for (int i = 0; i < PIN_DIGITS; i++) begin
         entry_val[i] = (digit_wr && (count_ff == CW'(i))) ? digit_val : digit_ff[i];
         if (entry_val[i] != pin_ext[4*(PIN_DIGITS-1-i) +: 4]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      prev_key_in     = key_eff;
      sensor_ready_in = sensor_ready_ff;
      alarm_in        = alarm_ff;
      admin_in        = admin_ff;
      count_in        = count_ff;
      disarm_in       = disarm_ff;
      stamp_in        = stamp_ff;
      ev              = mapc_pkg::EV_NONE;

      if (armed) begin
         if (!item.pir_level) begin
            sensor_ready_in = 1'b1;
         end
         if (sensor_ready_in && (item.pir_high_count >= cfg.vote_threshold)) begin
            sensor_ready_in = 1'b0;
            alarm_in        = 1'b1;
            ev              = mapc_pkg::EV_MOTION;
         end
      end

      if (alarm_in && !admin_ff) begin
         if (is_admin_key) begin
            admin_in = 1'b1;
            count_in = '0;
            ev       = mapc_pkg::EV_ADMIN;
         end
      end else if (admin_ff) begin
         if (is_digit) begin
            if (digit_wr) begin
               count_in = count_inc;
               ev       = mapc_pkg::EV_DIGIT;
            end
            if (count_in == CW'(PIN_DIGITS)) begin
               if (match) begin
                  alarm_in        = 1'b0;
                  admin_in        = 1'b0;
                  sensor_ready_in = 1'b1;
                  disarm_in       = 1'b1;
                  stamp_in        = item.now_us;
                  ev              = mapc_pkg::EV_PIN_OK;
               end else begin
                  count_in = '0;
                  ev       = mapc_pkg::EV_PIN_WRONG;
               end
            end
         end
      end else if (!alarm_in && disarm_ff) begin
         if (rearm_due) begin
            disarm_in       = 1'b0;
            sensor_ready_in = 1'b1;
            ev              = mapc_pkg::EV_REARMED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_key_ff     <= '0;
         sensor_ready_ff <= 1'b1;
         alarm_ff        <= 1'b0;
         admin_ff        <= 1'b0;
         count_ff        <= '0;
         disarm_ff       <= 1'b0;
         stamp_ff        <= '0;
      end else if (step) begin
         prev_key_ff     <= prev_key_in;
         sensor_ready_ff <= sensor_ready_in;
         alarm_ff        <= alarm_in;
         admin_ff        <= admin_in;
         count_ff        <= count_in;
         disarm_ff       <= disarm_in;
         stamp_ff        <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PIN_DIGITS; i++) begin
         if (step && digit_wr && (count_ff == CW'(i))) begin
            digit_ff[i] <= digit_val;
         end
      end
   end

   assign result.alarm_active   = alarm_in;
   assign result.admin_active   = admin_in;
   assign result.disarmed       = disarm_in;
   assign result.digits_entered = 3'(count_in);
   assign result.event_res      = ev;

endmodule

// ===== sv/motion_alarm_pin_controller_unit.sv =====
// Top level of the motion alarm PIN controller: input register, core, result register.
// Depends on mapc_pkg, mapc_csr and mapc_core.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | req_tdata: key, level, votes, time
//   rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: flags, digit count, event
//   csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One beat per cycle sustained while rsp_tready stays high; a request beat is held in
// the input register, then its result in the result register.
// Reset clears alarm state, not the PIN digits, and loads the configuration defaults.
// A stalled result holds in the result register; the input register keeps
// accepting one more beat, and req_tready drops only when both stages are full.
// csr_ready is always high.
module motion_alarm_pin_controller_unit #(
   parameter int PIN_DIGITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] key, [8] pir_level, [11:9] pir_high_count, [74:12] now_us, [79:75] zero
   input  logic [mapc_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] alarm_active, [1] admin_active, [2] disarmed, [5:3] digits_entered,
   // [8:6] event_res, [15:9] zero
   output logic [mapc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mapc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mapc_pkg::CSR_DATA_W-1:0]       csr_data
);

   mapc_pkg::cfg_type    cfg;
   mapc_pkg::item_type   in_ff, in_in;
   logic                 in_valid_ff;
   mapc_pkg::result_type rsp_ff, core_result;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_take;

   assign csr_ready = 1'b1;

   mapc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_in.key            = req_tdata[7:0];
   assign in_in.pir_level      = req_tdata[8];
   assign in_in.pir_high_count = req_tdata[11:9];
   assign in_in.now_us         = req_tdata[74:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
   end

   mapc_core #(
      .PIN_DIGITS (PIN_DIGITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.event_res, rsp_ff.digits_entered,
                        rsp_ff.disarmed, rsp_ff.admin_active, rsp_ff.alarm_active};

`ifndef SYNTHESIS
   a_admin_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.admin_active || rsp_ff.alarm_active))
      else $error("PIN mode reported without a latched alarm");

   a_disarm_excludes_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.disarmed && rsp_ff.alarm_active))
      else $error("alarm latched during disarm hold");

   a_pin_ok_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res == mapc_pkg::EV_PIN_OK))
      |-> (rsp_ff.disarmed && !rsp_ff.admin_active))
      else $error("PIN accepted without entering disarm hold");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_ff)))
      else $error("held request beat lost or overwritten");
`endif

endmodule

// ===== bench/tb_motion_alarm_pin_controller_unit.sv =====
// Self-checking bench for motion_alarm_pin_controller_unit: poll ticks in, one status beat out.
// Keeps its own alarm/PIN state model and checks every result beat field by field.
// Depends on mapc_pkg and the RTL top level only.
module tb_motion_alarm_pin_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIN_LEN        = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [7:0] KEY_A  = 8'h41;
   localparam logic [7:0] KEY_B  = 8'h42;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [mapc_pkg::REQ_TDATA_W-1:0]     req_tdata = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [mapc_pkg::RSP_TDATA_W-1:0]     rsp_tdata;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [mapc_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [mapc_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   motion_alarm_pin_controller_unit #(.PIN_DIGITS(PIN_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // alarm model state and settings
   logic [15:0] pin_cfg   = mapc_pkg::PIN_CODE_RESET;
   logic [31:0] rearm_cfg = mapc_pkg::REARM_DELAY_RESET;
   logic [2:0]  vote_cfg  = mapc_pkg::VOTE_THRESHOLD_RESET;
   logic [7:0]  prior_key    = mapc_pkg::KEY_NONE;
   logic        sensor_armed = 1'b1;
   logic        alarm_set    = 1'b0;
   logic        pin_mode     = 1'b0;
   logic [3:0]  pin_entry [PIN_LEN] = '{default: 4'd0};
   logic [2:0]  digit_cnt    = 3'd0;
   logic        hold_on      = 1'b0;
   logic [62:0] hold_start   = '0;

   mapc_pkg::item_type    pending_ticks [$];
   mapc_pkg::result_type  expected_rsp [$];
   mapc_pkg::item_type    driven_item;
   mapc_pkg::result_type  rsp_want;
   mapc_pkg::result_type  rsp_head;

   logic [62:0] gen_now = '0;
   logic [7:0]  gen_prev_key = mapc_pkg::KEY_NONE;
   int          queued_total = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int          failures = 0;
   int          beats_checked = 0;
   int          quiet_cycles = 0;
   int          event_tally [8] = '{default: 0};

   function automatic mapc_pkg::result_type alarm_tick_result(input mapc_pkg::item_type it);
      logic [7:0]           k;
      mapc_pkg::event_type  ev;
      logic [62:0]          elapsed;
      logic [31:0]          pin_wide;
      bit                   match;
      mapc_pkg::result_type r;
      k = it.key;
      if (k == prior_key) k = mapc_pkg::KEY_NONE;
      prior_key = k;
      ev = mapc_pkg::EV_NONE;
      if (!alarm_set && !pin_mode && !hold_on) begin
         if (!it.pir_level) sensor_armed = 1'b1;
         if (sensor_armed && it.pir_high_count >= vote_cfg) begin
            sensor_armed = 1'b0;
            alarm_set = 1'b1;
            ev = mapc_pkg::EV_MOTION;
         end
      end
      if (alarm_set && !pin_mode) begin
         if (k == mapc_pkg::KEY_C || k == mapc_pkg::KEY_D || k == mapc_pkg::KEY_HASH
             || k == mapc_pkg::KEY_STAR) begin
            pin_mode = 1'b1;
            digit_cnt = 3'd0;
            ev = mapc_pkg::EV_ADMIN;
         end
      end else if (pin_mode) begin
         if (k >= mapc_pkg::KEY_ZERO && k <= mapc_pkg::KEY_NINE) begin
            if (digit_cnt < PIN_LEN) begin
               pin_entry[digit_cnt] = 4'(k - mapc_pkg::KEY_ZERO);
               digit_cnt++;
               ev = mapc_pkg::EV_DIGIT;
            end
            if (digit_cnt == PIN_LEN) begin
               pin_wide = {16'b0, pin_cfg};
               match = 1'b1;
               for (int i = 0; i < PIN_LEN; i++)
                  if (pin_entry[i] != pin_wide[4*(PIN_LEN-1-i) +: 4]) match = 1'b0;
               if (match) begin
                  alarm_set = 1'b0;
                  pin_mode = 1'b0;
                  sensor_armed = 1'b1;
                  hold_on = 1'b1;
                  hold_start = it.now_us;
                  ev = mapc_pkg::EV_PIN_OK;
               end else begin
                  digit_cnt = 3'd0;
                  ev = mapc_pkg::EV_PIN_WRONG;
               end
            end
         end
      end else if (!alarm_set && hold_on) begin
         elapsed = it.now_us - hold_start;
         if (elapsed > {31'b0, rearm_cfg}) begin
            hold_on = 1'b0;
            sensor_armed = 1'b1;
            ev = mapc_pkg::EV_REARMED;
         end
      end
      r.alarm_active   = alarm_set;
      r.admin_active   = pin_mode;
      r.disarmed       = hold_on;
      r.digits_entered = digit_cnt;
      r.event_res      = ev;
      return r;
   endfunction

   function automatic int draw_pause(input bit quiet, input int long_max);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, long_max);
   endfunction

   function automatic logic [62:0] short_dt();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return 63'($urandom_range(1, 2000));
      if (r < 97) return 63'($urandom);
      return 63'({$urandom, $urandom});
   endfunction

   function automatic logic [7:0] admin_key();
      case ($urandom_range(0, 3))
         0: return mapc_pkg::KEY_C;
         1: return mapc_pkg::KEY_D;
         2: return mapc_pkg::KEY_HASH;
         default: return mapc_pkg::KEY_STAR;
      endcase
   endfunction

   function automatic logic [7:0] filler_key();
      case ($urandom_range(0, 4))
         0: return mapc_pkg::KEY_NONE;
         1: return KEY_A;
         2: return KEY_B;
         3: return admin_key();
         default: return 8'($urandom_range(8'h3A, 8'hFF));
      endcase
   endfunction

   task automatic tick(input logic [7:0] key, input logic level, input logic [2:0] votes,
                       input logic [62:0] dt);
      mapc_pkg::item_type it;
      gen_now = gen_now + dt;
      it.key = key;
      it.pir_level = level;
      it.pir_high_count = votes;
      it.now_us = gen_now;
      pending_ticks.push_back(it);
      gen_prev_key = (key == gen_prev_key) ? mapc_pkg::KEY_NONE : key;
      queued_total++;
   endtask

   // a repeated key needs a release tick in between or it is swallowed
   task automatic press(input logic [7:0] key);
      if (key == gen_prev_key && key != mapc_pkg::KEY_NONE)
         tick(mapc_pkg::KEY_NONE, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
              short_dt());
      tick(key, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), short_dt());
   endtask

   // trip, PIN mode, wrong tries, right PIN, wait out the hold
   task automatic alarm_session();
      int          tries;
      logic [3:0]  nib;
      logic [3:0]  dg;
      logic [31:0] pin_wide;
      logic [62:0] ok_at;
      tick(mapc_pkg::KEY_NONE, 1'b0, 3'($urandom_range(0, 7)), short_dt());
      tick(mapc_pkg::KEY_NONE, 1'b1, 3'($urandom_range(vote_cfg, 7)), short_dt());
      repeat ($urandom_range(0, 2)) press(filler_key());
      press(admin_key());
      tries = $urandom_range(1, 3);
      pin_wide = {16'b0, pin_cfg};
      for (int t = 0; t < tries; t++) begin
         for (int d = 0; d < PIN_LEN; d++) begin
            if ($urandom_range(0, 4) == 0) press(filler_key());
            nib = pin_wide[4*(PIN_LEN-1-d) +: 4];
            dg = (t == tries - 1 && nib <= 4'd9) ? nib : 4'($urandom_range(0, 9));
            press(mapc_pkg::KEY_ZERO + {4'b0, dg});
            if ($urandom_range(0, 39) == 0) return;
         end
      end
      ok_at = gen_now;
      repeat ($urandom_range(0, 3))
         tick(mapc_pkg::KEY_NONE, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
              short_dt());
      if ($urandom_range(0, 3) == 0) begin
         tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, ok_at + {31'b0, rearm_cfg} - gen_now);
         tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, 63'd1);
      end else begin
         tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0,
              ok_at + {31'b0, rearm_cfg} + 63'd1 + 63'($urandom_range(0, 1000)) - gen_now);
      end
   endtask

   task automatic noise_burst();
      logic [7:0] k;
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 5))
            0: k = mapc_pkg::KEY_NONE;
            1: k = mapc_pkg::KEY_ZERO + 8'($urandom_range(0, 9));
            2: k = admin_key();
            default: k = 8'($urandom_range(0, 255));
         endcase
         repeat (($urandom_range(0, 4) == 0) ? 3 : 1)
            tick(k, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), short_dt());
      end
   endtask

   task automatic random_phase(input int budget);
      int first;
      first = queued_total;
      while (queued_total - first < budget) begin
         if ($urandom_range(0, 3) != 0) alarm_session();
         else noise_burst();
      end
   endtask

   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mapc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mapc_pkg::CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mapc_pkg::CSR_PIN_CODE:       pin_cfg = data[15:0];
         mapc_pkg::CSR_REARM_DELAY:    rearm_cfg = data;
         mapc_pkg::CSR_VOTE_THRESHOLD: vote_cfg = data[2:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] pin, input logic [31:0] delay,
                             input logic [2:0] thr);
      write_reg(mapc_pkg::CSR_PIN_CODE, {16'b0, pin});
      write_reg(mapc_pkg::CSR_REARM_DELAY, delay);
      write_reg(mapc_pkg::CSR_VOTE_THRESHOLD, {29'b0, thr});
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            rsp_want = alarm_tick_result(driven_item);
            expected_rsp.push_back(rsp_want);
            event_tally[rsp_want.event_res]++;
         end
         if ($urandom_range(0, 59) == 0) req_quiet = !req_quiet;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            driven_item = pending_ticks.pop_front();
            req_tdata <= {5'b0, driven_item.now_us, driven_item.pir_high_count,
                          driven_item.pir_level, driven_item.key};
            req_tvalid <= 1'b1;
            gap_left = draw_pause(req_quiet, 24);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("result beat 0x%h with no tick outstanding", rsp_tdata);
               failures++;
            end else begin
               rsp_head = expected_rsp.pop_front();
               beats_checked++;
               check_field("alarm_active", 3'(rsp_head.alarm_active), 3'(rsp_tdata[0]));
               check_field("admin_active", 3'(rsp_head.admin_active), 3'(rsp_tdata[1]));
               check_field("disarmed", 3'(rsp_head.disarmed), 3'(rsp_tdata[2]));
               check_field("digits_entered", rsp_head.digits_entered, rsp_tdata[5:3]);
               check_field("event_res", rsp_head.event_res, rsp_tdata[8:6]);
            end
         end
         if ($urandom_range(0, 59) == 0) rsp_quiet = !rsp_quiet;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = draw_pause(rsp_quiet, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[motion_alarm_pin_controller_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [62:0] ok_at;
      logic [15:0] rand_pin;
      // power-on settings: trip, wrong PIN, right PIN, hold boundary, combined tick
      tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, 63'd0);
      tick(mapc_pkg::KEY_NONE, 1'b1, 3'd2, 63'd10);
      tick(mapc_pkg::KEY_NONE, 1'b1, 3'd3, 63'd10);
      tick(KEY_A, 1'b1, 3'd7, 63'd10);
      tick(mapc_pkg::KEY_ZERO + 8'd1, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_C, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_C, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_NINE, 1'b1, 3'd6, 63'd10);
      tick(mapc_pkg::KEY_NINE, 1'b1, 3'd6, 63'd10);
      tick(mapc_pkg::KEY_NINE, 1'b1, 3'd6, 63'd10);
      tick(mapc_pkg::KEY_ZERO, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_ZERO, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_STAR, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_ZERO + 8'd7, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_ZERO + 8'd1, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_ZERO + 8'd2, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_ZERO + 8'd4, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_ZERO + 8'd5, 1'b0, 3'd0, 63'd10);
      ok_at = gen_now;
      tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, 63'd10);
      tick(mapc_pkg::KEY_NONE, 1'b1, 3'd7, 63'd10);
      tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, ok_at + {31'b0, rearm_cfg} - gen_now);
      tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, 63'd1);
      tick(mapc_pkg::KEY_NONE, 1'b0, 3'd0, 63'd5);
      tick(mapc_pkg::KEY_HASH, 1'b1, 3'd5, 63'd5);
      tick(mapc_pkg::KEY_D, 1'b0, 3'd0, 63'd5);
      tick(8'hFF, 1'b1, 3'd6, 63'd5);
      random_phase(300);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      set_config(16'h9087, 32'd0, 3'd0);
      gen_now = 63'h7FFF_FFFF_FFFF_FF00;
      random_phase(150);
      wait_idle();

      set_config(16'hFFFF, 32'hFFFF_FFFF, 3'd7);
      gen_now = 63'h7FFF_FFFF_F000_0000;
      random_phase(150);
      wait_idle();

      set_config(16'h0000, 32'd1000, 3'd5);
      gen_now = 63'({$urandom, $urandom});
      random_phase(200);
      wait_idle();

      for (int i = 0; i < 4; i++)
         rand_pin[4*i +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, 9));
      set_config(rand_pin, $urandom_range(0, 100000), 3'($urandom_range(0, 7)));
      random_phase(250);
      wait_idle();
      repeat (10) @(posedge clock);

      if (expected_rsp.size() != 0) begin
         $error("%0d result beats never arrived", expected_rsp.size());
         failures++;
      end
      $display("Checked %0d status beats over 5 register sets, PIN/hold/vote at extremes.",
               beats_checked);
      $display("Events: %0d trips, %0d PIN entries, %0d digits, %0d good, %0d bad, %0d rearms.",
               event_tally[mapc_pkg::EV_MOTION], event_tally[mapc_pkg::EV_ADMIN],
               event_tally[mapc_pkg::EV_DIGIT], event_tally[mapc_pkg::EV_PIN_OK],
               event_tally[mapc_pkg::EV_PIN_WRONG], event_tally[mapc_pkg::EV_REARMED]);
      if (failures == 0) begin
         $display("[motion_alarm_pin_controller_unit] OK");
      end else begin
         $display("[motion_alarm_pin_controller_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mapc_pkg.sv
sv/mapc_csr.sv
sv/mapc_core.sv
sv/motion_alarm_pin_controller_unit.sv
bench/tb_motion_alarm_pin_controller_unit.sv
